// ===== sv/rtkt_pkg.sv =====
// package for the running top-k tracker: sizes, codes, state and control types
// used by the interfaces, the cell, the controller and the top level
package rtkt_pkg;

  localparam int MaxK  = 16;
  localparam int DataW = 32;
  localparam int RcW   = 5;
  localparam int CntW  = $clog2(MaxK + 1);
  localparam int CmpW  = (CntW > RcW) ? CntW : RcW;

  localparam logic [RcW-1:0] RcReset = RcW'(16);

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdCheck  = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StEmit,
    StEmpty,
    StRestore
  } state_e;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

endpackage

// ===== sv/rtkt_if.sv =====
// channel interfaces of the tracker: input word, result word, config write
// depends on rtkt_pkg
interface rtkt_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [rtkt_pkg::DataW-1:0] value;
  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface rtkt_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [rtkt_pkg::DataW-1:0] result_value;
  logic                           last;
  logic                           empty_res;
  modport source (output valid, output result_value, output last, output empty_res,
                  input ready);
  modport sink (input valid, input result_value, input last, input empty_res,
                output ready);
endinterface

interface rtkt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rtkt_pkg::RcW-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rtkt_cell.sv =====
// one slot of the sorted store: compare-and-shift on insert, rotate on readout
// depends on rtkt_pkg
module rtkt_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rtkt_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [rtkt_pkg::DataW-1:0] value_i,
  input  logic signed [rtkt_pkg::DataW-1:0] up_val_i,
  input  logic                              up_valid_i,
  input  logic                              up_gt_i,
  input  logic signed [rtkt_pkg::DataW-1:0] dn_val_i,
  input  logic                              dn_valid_i,
  output logic signed [rtkt_pkg::DataW-1:0] val_o,
  output logic                              valid_o,
  output logic                              gt_o
);
  import rtkt_pkg::*;

  logic signed [DataW-1:0] val_q, val_d;
  logic                    valid_q, valid_d;
  logic                    gt;

  assign gt = !valid_q || (value_i > val_q);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.rotate) begin
      val_d   = dn_val_i;
      valid_d = dn_valid_i;
    end else if (ctrl_i.insert && gt) begin
      if (up_gt_i) begin
        val_d   = up_val_i;
        valid_d = up_valid_i;
      end else begin
        val_d   = value_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      val_q   <= val_d;
      valid_q <= valid_d;
    end
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign gt_o    = gt;

endmodule

// ===== sv/rtkt_ctrl.sv =====
// sequencer of the tracker: handshakes, fill count, report length, readout walk
// depends on rtkt_pkg
module rtkt_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_cmd_i,
  output logic                     in_ready_o,
  input  logic                     cfg_valid_i,
  input  logic [rtkt_pkg::RcW-1:0] cfg_data_i,
  output logic                     cfg_ready_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic                     out_last_o,
  output logic                     out_empty_o,
  output rtkt_pkg::cell_ctrl_t     cell_ctrl_o
);
  import rtkt_pkg::*;

  state_e          state_q, state_d;
  logic [RcW-1:0]  rc_q, rc_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] step_q, step_d;
  logic [CmpW-1:0] rc_ext, kmax, k_new;
  logic            in_acc, out_acc, emit_last;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign emit_last = (step_q == k_q - CntW'(1));

  assign rc_ext = CmpW'(rc_q);
  assign kmax   = (rc_ext > CmpW'(MaxK)) ? CmpW'(MaxK) : rc_ext;
  assign k_new  = (kmax > CmpW'(count_q)) ? CmpW'(count_q) : kmax;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && in_cmd_i == CmdCheck) begin
          state_d = (k_new == '0) ? StEmpty : StEmit;
        end
      end
      StEmit: begin
        if (out_acc && emit_last) begin
          state_d = (k_q == CntW'(MaxK)) ? StIdle : StRestore;
        end
      end
      StEmpty: begin
        if (out_acc) begin
          state_d = StIdle;
        end
      end
      StRestore: begin
        if (step_q == CntW'(MaxK - 1)) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o         = 1'b0;
    out_valid_o        = 1'b0;
    out_last_o         = 1'b0;
    out_empty_o        = 1'b0;
    cell_ctrl_o.insert = 1'b0;
    cell_ctrl_o.rotate = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o         = 1'b1;
        cell_ctrl_o.insert = in_valid_i && in_cmd_i == CmdInsert;
      end
      StEmit: begin
        out_valid_o        = 1'b1;
        out_last_o         = emit_last;
        cell_ctrl_o.rotate = out_ready_i;
      end
      StEmpty: begin
        out_valid_o = 1'b1;
        out_last_o  = 1'b1;
        out_empty_o = 1'b1;
      end
      StRestore: begin
        cell_ctrl_o.rotate = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    rc_d    = rc_q;
    count_d = count_q;
    k_d     = k_q;
    step_d  = step_q;
    if (cfg_valid_i && cfg_ready_o) begin
      rc_d = cfg_data_i;
    end
    if (cell_ctrl_o.insert && count_q != CntW'(MaxK)) begin
      count_d = count_q + CntW'(1);
    end
    if (in_acc && in_cmd_i == CmdCheck) begin
      k_d    = CntW'(k_new);
      step_d = '0;
    end
    if (cell_ctrl_o.rotate) begin
      step_d = step_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rc_q    <= RcReset;
      count_q <= '0;
      k_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      rc_q    <= rc_d;
      count_q <= count_d;
      k_q     <= k_d;
      step_q  <= step_d;
    end
  end

endmodule

// ===== sv/running_top_k_tracker_unit.sv =====
// top level: row of rtkt_cell slots driven by rtkt_ctrl
// rate: an insert word is taken every cycle while no check is running
// a check shows its first result the cycle after acceptance; the row then rotates
// once per taken result and finishes a full turn; a check holds the input until
// the turn ends, output stalls included; an empty check until its result is taken
// reset: all slots invalid, report_count 16, ready for input right after reset
module running_top_k_tracker_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  rtkt_in_if.sink    in_i,
  rtkt_cfg_if.sink   cfg_i,
  rtkt_out_if.source res_o
);
  import rtkt_pkg::*;

  cell_ctrl_t              cell_ctrl;
  logic signed [DataW-1:0] cell_val   [MaxK];
  logic                    cell_valid [MaxK];
  logic                    cell_gt    [MaxK];
  logic                    empty;

  rtkt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.command),
    .in_ready_o  (in_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .out_last_o  (res_o.last),
    .out_empty_o (empty),
    .cell_ctrl_o (cell_ctrl)
  );

  for (genvar i = 0; i < MaxK; i++) begin : g_cell
    logic signed [DataW-1:0] up_val;
    logic                    up_valid;
    logic                    up_gt;
    if (i == 0) begin : g_head
      assign up_val   = '0;
      assign up_valid = 1'b1;
      assign up_gt    = 1'b0;
    end else begin : g_body
      assign up_val   = cell_val[i-1];
      assign up_valid = cell_valid[i-1];
      assign up_gt    = cell_gt[i-1];
    end
    rtkt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .value_i    (in_i.value),
      .up_val_i   (up_val),
      .up_valid_i (up_valid),
      .up_gt_i    (up_gt),
      .dn_val_i   (cell_val[(i + 1) % MaxK]),
      .dn_valid_i (cell_valid[(i + 1) % MaxK]),
      .val_o      (cell_val[i]),
      .valid_o    (cell_valid[i]),
      .gt_o       (cell_gt[i])
    );
  end

  assign res_o.empty_res    = empty;
  assign res_o.result_value = empty ? '0 : cell_val[0];

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for running_top_k_tracker_unit: directed and random insert and check words,
// compared against a sorted-store predictor; depends on rtkt_pkg and the rtkt_if interfaces
module tb_top;
  import rtkt_pkg::*;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    last;
    logic                    empty_res;
  } top_entry_t;

  localparam int StallLimit = 1000;

  logic clk_i;
  logic rst_ni;

  rtkt_in_if  in_if ();
  rtkt_cfg_if cfg_if ();
  rtkt_out_if res_if ();

  running_top_k_tracker_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  logic signed [DataW-1:0] ranked_q [MaxK];
  int unsigned             stored_n;
  logic [RcW-1:0]          report_count_q;
  top_entry_t              pending_reports [$];
  top_entry_t              head_entry;

  int src_idle_pct;
  int snk_idle_pct;
  int words_sent;
  int checks_sent;
  int results_seen;
  int cfg_writes;
  int error_count;
  int stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // keep the top MaxK values in descending order; ties go behind the equal ones
  function automatic void store_insert(input logic signed [DataW-1:0] val);
    int unsigned pos;
    pos = 0;
    while (pos < stored_n && !(val > ranked_q[pos])) pos++;
    if (pos >= MaxK) return;
    if (stored_n < MaxK) stored_n++;
    for (int unsigned i = stored_n - 1; i > pos; i--) ranked_q[i] = ranked_q[i - 1];
    ranked_q[pos] = val;
  endfunction

  function automatic void predict_report();
    int unsigned k;
    top_entry_t  e;
    k = report_count_q;
    if (k > MaxK) k = MaxK;
    if (k > stored_n) k = stored_n;
    if (k == 0) begin
      e.value     = '0;
      e.last      = 1'b1;
      e.empty_res = 1'b1;
      pending_reports.push_back(e);
    end else begin
      for (int unsigned i = 0; i < k; i++) begin
        e.value     = ranked_q[i];
        e.last      = (i + 1 == k);
        e.empty_res = 1'b0;
        pending_reports.push_back(e);
      end
    end
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    logic signed [DataW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3: begin
        case ($urandom_range(3))
          0: v = 32'sh7FFFFFFF;
          1: v = 32'sh80000000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      4, 5, 6: begin
        if (stored_n > 0) v = ranked_q[$urandom_range(stored_n - 1)] + $urandom_range(8) - 4;
        else v = $urandom;
      end
      7: v = $urandom_range(64) - 32;
      default: begin
        if (stored_n > 0) v = ranked_q[$urandom_range(stored_n - 1)];
        else v = $urandom;
      end
    endcase
    return v;
  endfunction

  function automatic logic [RcW-1:0] pick_report_count();
    logic [RcW-1:0] rc;
    case ($urandom_range(5))
      0: rc = '0;
      1: rc = RcW'(MaxK);
      2: rc = '1;
      default: rc = RcW'($urandom_range(31, 1));
    endcase
    return rc;
  endfunction

  // entered and left at a falling edge; valid stays high so the next word can follow
  task automatic send_word(input logic cmd, input logic signed [DataW-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.value   <= val;
    do @(posedge clk_i); while (!in_if.ready);
    if (cmd == CmdInsert) begin
      store_insert(val);
    end else begin
      predict_report();
      checks_sent++;
    end
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    // let the row finish its turn after the final result
    repeat (MaxK + 4) @(negedge clk_i);
  endtask

  task automatic write_report_count(input logic [RcW-1:0] rc);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= rc;
    do @(posedge clk_i); while (!cfg_if.ready);
    report_count_q = rc;
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_empty_store();
    send_word(CmdCheck, 32'sh12345678);
    wait_drained();
  endtask

  task automatic test_extremes();
    send_word(CmdInsert, 32'sh7FFFFFFF);
    send_word(CmdInsert, 32'sh80000000);
    send_word(CmdInsert, 32'sh00000000);
    send_word(CmdInsert, -32'sd1);
    send_word(CmdInsert, 32'sd1);
    send_word(CmdInsert, 32'sh00000000);
    send_word(CmdCheck, 32'shFFFFFFFF);
    wait_drained();
  endtask

  task automatic test_report_count_limits();
    write_report_count(RcW'(1));
    send_word(CmdCheck, '0);
    write_report_count('0);
    send_word(CmdCheck, '0);
    write_report_count('1);
    send_word(CmdCheck, '0);
    wait_drained();
  endtask

  task automatic test_full_store();
    for (int i = 100; i <= 110; i++) send_word(CmdInsert, i);
    // not larger than the smallest stored value, both dropped
    send_word(CmdInsert, 32'sh80000000);
    send_word(CmdInsert, -32'sd1);
    send_word(CmdCheck, '0);
    wait_drained();
  endtask

  task automatic run_random_phase(input int n_words, input int src_pct, input int snk_pct);
    int sent;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_words) begin
      if (sent % 32 == 0) write_report_count(pick_report_count());
      if ($urandom_range(5) == 0) send_word(CmdCheck, $urandom);
      else send_word(CmdInsert, pick_value());
      sent++;
    end
    wait_drained();
  endtask

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (pending_reports.size() == 0) begin
        $error("result word with none expected: result_value %0d last %0b empty_res %0b",
               res_if.result_value, res_if.last, res_if.empty_res);
        error_count++;
      end else begin
        head_entry = pending_reports.pop_front();
        if (res_if.result_value !== head_entry.value) begin
          $error("result_value: expected %0d, actual %0d", head_entry.value,
                 res_if.result_value);
          error_count++;
        end
        if (res_if.last !== head_entry.last) begin
          $error("last: expected %0b, actual %0b", head_entry.last, res_if.last);
          error_count++;
        end
        if (res_if.empty_res !== head_entry.empty_res) begin
          $error("empty_res: expected %0b, actual %0b", head_entry.empty_res,
                 res_if.empty_res);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("timeout: no word moved for %0d cycles", StallLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.command = CmdInsert;
    in_if.value   = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    src_idle_pct  = 29;
    snk_idle_pct  = 45;
    words_sent    = 0;
    checks_sent   = 0;
    results_seen  = 0;
    cfg_writes    = 0;
    error_count   = 0;
    stall_cycles  = 0;
    stored_n      = 0;
    report_count_q = RcReset;
    for (int i = 0; i < MaxK; i++) ranked_q[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_store();
    test_extremes();
    test_report_count_limits();
    test_full_store();
    run_random_phase(130, 29, 45);
    run_random_phase(130, 45, 29);
    run_random_phase(125, 0, 0);

    wait_drained();
    $display("sent %0d input words (%0d checks) over %0d report_count settings",
             words_sent, checks_sent, cfg_writes);
    $display("checked %0d result words under three idle patterns", results_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
